[design/ring_neighbor_resource_arbiter_macros.svh]
// ----------------------------------------------------------------------------
// Ring neighbor resource arbiter: assertion macros
// Shorthand for the clocked, reset-qualified properties used by the checker.
// ----------------------------------------------------------------------------
`ifndef RING_NEIGHBOR_RESOURCE_ARBITER_MACROS_SVH
`define RING_NEIGHBOR_RESOURCE_ARBITER_MACROS_SVH

// Same-cycle implication, sampled on i_clk, disabled while i_rst_n is low.
`define RNRA_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on i_clk, disabled while i_rst_n is low.
`define RNRA_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/rnra_pkg.sv]
// ----------------------------------------------------------------------------
// Ring neighbor resource arbiter: shared package
// Widths, defaults and the command and status types between controller and
// datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package rnra_pkg;

    localparam int NUM_CLIENTS_DEF = 10;
    localparam int CLIENT_W        = 4;
    localparam int IN_TDATA_W      = 8;
    localparam int OUT_FIELDS_W    = 11;
    localparam int OUT_TDATA_W     = 16;

    // Operation applied to the client lanes in one step.
    typedef enum logic [1:0] {
        OP_NONE,
        OP_HUNGRY,
        OP_THINK,
        OP_TEST
    } t_op;

    // Which lane a grant test looks at.
    typedef enum logic [1:0] {
        TGT_SELF,
        TGT_RIGHT,
        TGT_LEFT
    } t_target;

    typedef struct packed {
        logic    load;      // capture the incoming item
        t_op     op;
        t_target target;
        logic    emit;      // move the result into the output register
    } t_dp_cmd;

    typedef struct packed {
        logic cmd_put;      // captured command is a release
        logic out_free;     // output register can take a result this cycle
    } t_dp_status;

endpackage

`default_nettype wire

[design/rnra_ctrl.sv]
// ----------------------------------------------------------------------------
// Ring neighbor resource arbiter: controller
// Sequences one item through mark, grant test(s) and result hand-off.
// ----------------------------------------------------------------------------
`default_nettype none

module rnra_ctrl (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_s_tvalid,
    output logic                o_s_tready,
    input  rnra_pkg::t_dp_status i_status,
    output rnra_pkg::t_dp_cmd   o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MARK,
        S_TEST_SELF,
        S_TEST_RIGHT,
        S_TEST_LEFT,
        S_EMIT
    } t_state;

    t_state r_state, n_state;
    logic   r_ready, n_ready;
    logic   accept;

    assign accept     = i_s_tvalid & r_ready;
    assign o_s_tready = r_ready;

    always_comb begin
        n_state      = r_state;
        n_ready      = r_ready;
        o_cmd.load   = 1'b0;
        o_cmd.op     = rnra_pkg::OP_NONE;
        o_cmd.target = rnra_pkg::TGT_SELF;
        o_cmd.emit   = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_MARK;
                    n_ready    = 1'b0;
                end
            end
            S_MARK: begin
                if (i_status.cmd_put) begin
                    o_cmd.op = rnra_pkg::OP_THINK;
                    n_state  = S_TEST_RIGHT;
                end else begin
                    o_cmd.op = rnra_pkg::OP_HUNGRY;
                    n_state  = S_TEST_SELF;
                end
            end
            S_TEST_SELF: begin
                o_cmd.op     = rnra_pkg::OP_TEST;
                o_cmd.target = rnra_pkg::TGT_SELF;
                n_state      = S_EMIT;
            end
            S_TEST_RIGHT: begin
                o_cmd.op     = rnra_pkg::OP_TEST;
                o_cmd.target = rnra_pkg::TGT_RIGHT;
                n_state      = S_TEST_LEFT;
            end
            S_TEST_LEFT: begin
                o_cmd.op     = rnra_pkg::OP_TEST;
                o_cmd.target = rnra_pkg::TGT_LEFT;
                n_state      = S_EMIT;
            end
            S_EMIT: begin
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                    n_ready    = 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
                n_ready = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ready <= 1'b1;
        end else begin
            r_state <= n_state;
            r_ready <= n_ready;
        end
    end

endmodule

`default_nettype wire

[design/rnra_dp.sv]
// ----------------------------------------------------------------------------
// Ring neighbor resource arbiter: datapath
// One lane of phase bits per client, neighbor-wired grant tests, result flags
// and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module rnra_dp #(
    parameter int NUM_CLIENTS = rnra_pkg::NUM_CLIENTS_DEF
) (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  wire  [rnra_pkg::IN_TDATA_W-1:0]      i_s_tdata,
    input  rnra_pkg::t_dp_cmd                    i_cmd,
    output rnra_pkg::t_dp_status                 o_status,
    input  wire                                  i_m_tready,
    output logic                                 o_m_tvalid,
    output logic [rnra_pkg::OUT_TDATA_W-1:0]     o_m_tdata
);

    localparam int IW = ($clog2(NUM_CLIENTS) > rnra_pkg::CLIENT_W) ?
                        $clog2(NUM_CLIENTS) : rnra_pkg::CLIENT_W;
    localparam logic [IW-1:0] LAST = IW'(NUM_CLIENTS - 1);
    localparam int PAD_W = rnra_pkg::OUT_TDATA_W - rnra_pkg::OUT_FIELDS_W;

    // Captured item.
    logic                          r_cmd_put;
    logic [rnra_pkg::CLIENT_W-1:0] r_client;

    // Phase per client: eating, hungry, or thinking when neither bit is set.
    logic [NUM_CLIENTS-1:0] r_eat, n_eat;
    logic [NUM_CLIENTS-1:0] r_hungry, n_hungry;

    logic r_granted, r_wake_r, r_wake_l;
    logic r_m_tvalid;
    logic [rnra_pkg::OUT_TDATA_W-1:0] r_m_tdata;

    logic [IW-1:0] c_ext, right_idx, left_idx;
    logic          in_range;
    logic [NUM_CLIENTS-1:0] sel_c, sel_r, sel_l, sel_t, cond, hit_vec;
    logic          hit;
    logic [rnra_pkg::CLIENT_W-1:0] right_out, left_out;

    assign c_ext     = IW'(r_client);
    assign in_range  = (c_ext <= LAST);
    assign right_idx = (c_ext == LAST) ? '0 : c_ext + IW'(1);
    assign left_idx  = (c_ext == '0) ? LAST : c_ext - IW'(1);

    // Neighbor fields leave the block masked to the field width.
    assign right_out = in_range ? right_idx[rnra_pkg::CLIENT_W-1:0] : '0;
    assign left_out  = in_range ? left_idx[rnra_pkg::CLIENT_W-1:0] : '0;

    for (genvar i = 0; i < NUM_CLIENTS; i++) begin : g_lane
        localparam int RI = (i + 1) % NUM_CLIENTS;
        localparam int LI = (i + NUM_CLIENTS - 1) % NUM_CLIENTS;
        assign sel_c[i] = (c_ext == IW'(i));
        assign sel_r[i] = in_range & (right_idx == IW'(i));
        assign sel_l[i] = in_range & (left_idx == IW'(i));
        // A hungry client may eat when neither ring neighbor is eating.
        assign cond[i]  = r_hungry[i] & ~r_eat[RI] & ~r_eat[LI];
    end

    always_comb begin
        case (i_cmd.target)
            rnra_pkg::TGT_SELF:  sel_t = sel_c;
            rnra_pkg::TGT_RIGHT: sel_t = sel_r;
            rnra_pkg::TGT_LEFT:  sel_t = sel_l;
            default:             sel_t = '0;
        endcase
    end

    assign hit_vec = sel_t & cond;
    assign hit     = |hit_vec;

    always_comb begin
        n_eat    = r_eat;
        n_hungry = r_hungry;
        case (i_cmd.op)
            rnra_pkg::OP_HUNGRY: begin
                n_hungry = r_hungry | sel_c;
                n_eat    = r_eat & ~sel_c;
            end
            rnra_pkg::OP_THINK: begin
                n_hungry = r_hungry & ~sel_c;
                n_eat    = r_eat & ~sel_c;
            end
            rnra_pkg::OP_TEST: begin
                n_eat    = r_eat | hit_vec;
                n_hungry = r_hungry & ~hit_vec;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eat      <= '0;
            r_hungry   <= '0;
            r_m_tvalid <= 1'b0;
        end else begin
            r_eat    <= n_eat;
            r_hungry <= n_hungry;
            if (i_cmd.emit) begin
                r_m_tvalid <= 1'b1;
            end else if (i_m_tready) begin
                r_m_tvalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cmd_put <= i_s_tdata[0];
            r_client  <= i_s_tdata[rnra_pkg::CLIENT_W:1];
            r_granted <= 1'b0;
            r_wake_r  <= 1'b0;
            r_wake_l  <= 1'b0;
        end else if (i_cmd.op == rnra_pkg::OP_TEST) begin
            case (i_cmd.target)
                rnra_pkg::TGT_SELF:  r_granted <= hit;
                rnra_pkg::TGT_RIGHT: r_wake_r  <= hit;
                rnra_pkg::TGT_LEFT:  r_wake_l  <= hit;
                default: begin
                end
            endcase
        end
        if (i_cmd.emit) begin
            r_m_tdata <= {{PAD_W{1'b0}}, left_out, r_wake_l, right_out, r_wake_r, r_granted};
        end
    end

    assign o_status.cmd_put  = r_cmd_put;
    assign o_status.out_free = ~r_m_tvalid | i_m_tready;
    assign o_m_tvalid        = r_m_tvalid;
    assign o_m_tdata         = r_m_tdata;

endmodule

`default_nettype wire

[design/ring_neighbor_resource_arbiter.sv]
// ----------------------------------------------------------------------------
// Ring neighbor resource arbiter
// Grants clients in a ring the two resources they share with their neighbors.
// ----------------------------------------------------------------------------
// Usage: each input item on the slave stream carries a command and a client
// index. A take marks the client hungry and grants it when neither ring
// neighbor is eating. A put sends the client back to thinking and then tests
// its right neighbor, then its left one, granting each that is hungry with no
// eating neighbor of its own. Every item yields exactly one result item on the
// master stream with the grant flag, both wake flags and both neighbor indices.
// A client index at or above the ring size changes nothing and gives an
// all-zero result.
// Timing: the controller walks one item at a time through a mark step, one
// grant test (take) or two (put), and a hand-off step into the output
// register; a new item is taken only after the result of the last one has
// been moved into the output register.
// Reset: synchronous and active low; every client starts thinking and the
// output register is empty. If the receiver stalls, the result holds in the
// output register and the block stops in its hand-off step until it drains.
// ----------------------------------------------------------------------------
`default_nettype none

module ring_neighbor_resource_arbiter #(
    parameter int NUM_CLIENTS = rnra_pkg::NUM_CLIENTS_DEF
) (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    // tdata fields from bit 0: cmd (1 bit, 1 = put), client (4 bits).
    input  wire                               s_tvalid,
    output logic                              s_tready,
    input  wire  [rnra_pkg::IN_TDATA_W-1:0]   s_tdata,
    // tdata fields from bit 0: granted_now (1), wake_right (1),
    // right_client (4), wake_left (1), left_client (4).
    output logic                              m_tvalid,
    input  wire                               m_tready,
    output logic [rnra_pkg::OUT_TDATA_W-1:0]  m_tdata
);

    rnra_pkg::t_dp_cmd    dp_cmd;
    rnra_pkg::t_dp_status dp_status;

    // Sequencer: one step per cycle unless the hand-off step waits on a stalled output, one item in flight.
    rnra_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_status   (dp_status),
        .o_cmd      (dp_cmd)
    );

    // Phase lanes, neighbor tests and the output register.
    rnra_dp #(
        .NUM_CLIENTS (NUM_CLIENTS)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tdata  (s_tdata),
        .i_cmd      (dp_cmd),
        .o_status   (dp_status),
        .i_m_tready (m_tready),
        .o_m_tvalid (m_tvalid),
        .o_m_tdata  (m_tdata)
    );

endmodule

`default_nettype wire

[design/rnra_checker.sv]
// ----------------------------------------------------------------------------
// Ring neighbor resource arbiter: port checker
// Watches the top-level streams for ordering, hold and field sanity.
// ----------------------------------------------------------------------------
`default_nettype none

`include "ring_neighbor_resource_arbiter_macros.svh"

module rnra_checker #(
    parameter int NUM_CLIENTS = rnra_pkg::NUM_CLIENTS_DEF
) (
    input wire                              i_clk,
    input wire                              i_rst_n,
    input wire                              s_tvalid,
    input wire                              s_tready,
    input wire [rnra_pkg::IN_TDATA_W-1:0]   s_tdata,
    input wire                              m_tvalid,
    input wire                              m_tready,
    input wire [rnra_pkg::OUT_TDATA_W-1:0]  m_tdata
);

    logic s_acc;
    logic m_stall;
    logic grant_f;
    logic wake_f;
    logic idx_ok;

    assign s_acc   = s_tvalid && s_tready;
    assign m_stall = m_tvalid && !m_tready;
    assign grant_f = m_tdata[0];
    assign wake_f  = m_tdata[1] || m_tdata[6];
    assign idx_ok  = (int'(m_tdata[5:2]) < NUM_CLIENTS) &&
                     (int'(m_tdata[10:7]) < NUM_CLIENTS);

    // A stalled result must hold.
    `RNRA_ASSERT_NXT(a_out_hold, m_stall, m_tvalid && $stable(m_tdata), "stalled result changed")

    // Only one item is in flight: the input closes right after an accept.
    `RNRA_ASSERT_NXT(a_one_in_flight, s_acc, !s_tready, "second item taken while busy")

    // A take never wakes neighbors and a put never grants its own client.
    `RNRA_ASSERT_IMP(a_flags_exclusive, m_tvalid, !(grant_f && wake_f), "grant and wake together")

    // Neighbor indices stay inside the ring.
    `RNRA_ASSERT_IMP(a_idx_range, m_tvalid, idx_ok, "neighbor index outside the ring")

endmodule

bind ring_neighbor_resource_arbiter rnra_checker #(
    .NUM_CLIENTS (NUM_CLIENTS)
) u_rnra_checker (.*);

`default_nettype wire
